// File: rtl/bmsfs_pkg.sv
// Shared types, constants and helpers for the frame sync and cell assembly block.
// No dependencies; imported by every module of the block.
package bmsfs_pkg;

    localparam int FRAME_BYTES    = 13;
    localparam int WIN_KEEP       = FRAME_BYTES - 1;
    localparam int MAX_SLOTS      = 16;
    localparam int MAX_CELL_COUNT = 48;
    localparam int NUM_PAY        = 8;
    localparam int PAY_OFS        = 4;
    localparam int CMD_OFS        = 2;

    localparam logic [7:0] SYNC_BYTE      = 8'hA5;
    localparam logic [7:0] CMD_STATUS     = 8'h94;
    localparam logic [7:0] CMD_CELLS      = 8'h95;
    localparam logic [5:0] FALLBACK_CELLS = 6'd8;
    localparam logic [4:0] RESET_FRAMES   = 5'd3;

    typedef enum logic [2:0] {
        CS_NONE      = 3'd0,
        CS_ACCEPTED  = 3'd1,
        CS_RANGE     = 3'd2,
        CS_ASSEMBLED = 3'd3,
        CS_DUP       = 3'd4
    } t_cell_status;

    // front -> back: either a validated frame or a request marker
    typedef struct packed {
        logic                    is_req;
        logic [7:0]              fcmd;
        logic [NUM_PAY-1:0][7:0] pay;
    } t_cmd_entry;

    typedef struct packed {
        logic [7:0]              fcmd;
        logic [NUM_PAY-1:0][7:0] pay;
        t_cell_status            status;
        logic [3:0]              slot;
        logic                    complete;
    } t_result;

    // ceil(n/3) for n <= 63: floor(m/3) == (m*171) >> 9 for m < 256
    function automatic logic [4:0] ceil_third(input logic [5:0] n);
        logic [7:0]  m;
        logic [15:0] p;
        m = {2'b00, n} + 8'd2;
        p = {8'd0, m} * 16'd171;
        return p[13:9];
    endfunction

endpackage

// File: rtl/bmsfs_front.sv
// Front end: 12-byte receive window for 13-byte frames, running checksum and sync check.
// Emits validated frames and request markers into the command queue. Uses bmsfs_pkg.
module bmsfs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_cmd,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_wr,
    output bmsfs_pkg::t_cmd_entry o_entry
);
    import bmsfs_pkg::*;

    logic [7:0] r_win [WIN_KEEP];
    logic [3:0] r_fill;
    logic [7:0] r_sum;   // sum of bytes held in the window
    logic [3:0] n_fill;
    logic [7:0] n_sum;
    logic       win_full;
    logic       frame_ok;
    logic       take_byte;

    // byte 12 (checksum) is never stored; it is compared on arrival
    assign win_full  = (r_fill == 4'(WIN_KEEP));
    assign frame_ok  = win_full && (r_win[0] == SYNC_BYTE) && (r_sum == i_rx_byte);
    assign take_byte = i_accept && !i_cmd;
    assign o_wr      = i_accept && (i_cmd || frame_ok);

    always_comb begin
        o_entry.is_req = i_cmd;
        o_entry.fcmd   = r_win[CMD_OFS];
        for (int k = 0; k < NUM_PAY; k++) begin
            o_entry.pay[k] = r_win[PAY_OFS + k];
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_sum  = r_sum;
        if (take_byte) begin
            if (!win_full) begin
                n_fill = r_fill + 4'd1;
                n_sum  = r_sum + i_rx_byte;
            end else if (frame_ok) begin
                n_fill = '0;
                n_sum  = '0;
            end else begin
                n_sum = r_sum - r_win[0] + i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_byte) begin
            if (!win_full) begin
                r_win[r_fill] <= i_rx_byte;
            end else if (!frame_ok) begin
                // drop oldest word
                for (int k = 0; k < WIN_KEEP - 1; k++) begin
                    r_win[k] <= r_win[k + 1];
                end
                r_win[WIN_KEEP - 1] <= i_rx_byte;
            end
        end
    end

endmodule

// File: rtl/bmsfs_cmdq.sv
// Two-entry queue between the front end and the assembly tracker.
// Uses bmsfs_pkg for the entry type.
module bmsfs_cmdq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  bmsfs_pkg::t_cmd_entry i_data,
    input  logic                  i_rd,
    output logic                  o_empty,
    output logic                  o_full,
    output bmsfs_pkg::t_cmd_entry o_data
);
    import bmsfs_pkg::*;

    t_cmd_entry r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_wr;
    logic       do_rd;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= !r_wp;
            end
            if (do_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/bmsfs_back.sv
// Back end: cell-voltage frame reassembly tracker and two-entry result queue.
// Consumes command queue entries; uses bmsfs_pkg.
module bmsfs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_wdata,
    input  logic                  i_q_empty,
    input  bmsfs_pkg::t_cmd_entry i_q_data,
    output logic                  o_q_rd,
    input  logic                  i_pop,
    output logic                  o_empty,
    output bmsfs_pkg::t_result    o_res
);
    import bmsfs_pkg::*;

    logic [15:0] r_seen;
    logic        r_assembled;
    logic        r_base_known;
    logic        r_base_one;
    logic [4:0]  r_frames_needed;

    logic [15:0] n_seen;
    logic        n_assembled;
    logic        n_base_known;
    logic        n_base_one;
    logic [4:0]  n_frames_needed;

    t_result     r_oq [2];
    logic        r_owp;
    logic        r_orp;
    logic [1:0]  r_ocnt;

    t_result      res;
    logic         is_cells;
    logic         is_status;
    logic [7:0]   raw;
    logic [7:0]   idx;
    logic         base_one;
    logic [16:0]  mask_ext;
    logic [15:0]  mask;
    logic [5:0]   cfg_cells;
    logic         o_wr;
    logic         o_rd;

    assign o_q_rd  = !i_q_empty && (r_ocnt != 2'd2);
    assign o_wr    = o_q_rd && !i_q_data.is_req;
    assign o_rd    = i_pop && !o_empty;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

    assign is_cells  = (i_q_data.fcmd == CMD_CELLS);
    assign is_status = (i_q_data.fcmd == CMD_STATUS);
    assign raw       = i_q_data.pay[0];
    assign base_one  = r_base_known ? r_base_one : (raw != 8'd0);
    assign idx       = raw - {7'd0, base_one};
    assign mask_ext  = (17'd1 << r_frames_needed) - 17'd1;
    assign mask      = mask_ext[15:0];

    always_comb begin
        if (i_cfg_wdata == 6'd0) begin
            cfg_cells = FALLBACK_CELLS;
        end else if (i_cfg_wdata > 6'(MAX_CELL_COUNT)) begin
            cfg_cells = 6'(MAX_CELL_COUNT);
        end else begin
            cfg_cells = i_cfg_wdata;
        end
    end

    always_comb begin
        n_seen          = r_seen;
        n_assembled     = r_assembled;
        n_base_known    = r_base_known;
        n_base_one      = r_base_one;
        n_frames_needed = r_frames_needed;
        res.fcmd        = i_q_data.fcmd;
        res.pay         = i_q_data.pay;
        res.status      = CS_NONE;
        res.slot        = '0;

        if (i_cfg_we) begin
            n_frames_needed = ceil_third(cfg_cells);
        end

        if (o_q_rd) begin
            if (i_q_data.is_req) begin
                n_seen       = '0;
                n_assembled  = 1'b0;
                n_base_known = 1'b0;
            end else if (is_status) begin
                if (raw >= 8'd1 && raw <= 8'(MAX_CELL_COUNT)) begin
                    n_frames_needed = ceil_third(raw[5:0]);
                    n_seen          = '0;
                    n_assembled     = 1'b0;
                end
            end else if (is_cells) begin
                n_base_known = 1'b1;
                n_base_one   = base_one;
                // raw below base wraps idx high, so one compare covers both range cases
                if (idx >= 8'(MAX_SLOTS)) begin
                    res.status = CS_RANGE;
                end else begin
                    res.slot = idx[3:0];
                    if (r_assembled) begin
                        res.status = CS_ASSEMBLED;
                    end else if (r_seen[idx[3:0]]) begin
                        res.status = CS_DUP;
                    end else begin
                        res.status = CS_ACCEPTED;
                        n_seen     = r_seen | (16'd1 << idx[3:0]);
                        if ((n_seen & mask) == mask) begin
                            n_assembled = 1'b1;
                        end
                    end
                end
            end
        end
        res.complete = n_assembled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen          <= '0;
            r_assembled     <= 1'b0;
            r_base_known    <= 1'b0;
            r_base_one      <= 1'b0;
            r_frames_needed <= RESET_FRAMES;
            r_owp           <= 1'b0;
            r_orp           <= 1'b0;
            r_ocnt          <= '0;
        end else begin
            r_seen          <= n_seen;
            r_assembled     <= n_assembled;
            r_base_known    <= n_base_known;
            r_base_one      <= n_base_one;
            r_frames_needed <= n_frames_needed;
            if (o_wr) begin
                r_owp <= !r_owp;
            end
            if (o_rd) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, o_wr} - {1'b0, o_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr) begin
            r_oq[r_owp] <= res;
        end
    end

endmodule

// File: rtl/bms_frame_sync_and_cell_assembly_top.sv
// Serial frame sync and cell-voltage assembly. A received byte (or request
// marker) is accepted every cycle while full is low. The front end keeps a
// 12-byte window with a running 8-bit sum, so a frame is validated in the cycle
// its checksum byte arrives; validated frames and request markers pass through
// a two-entry queue to the assembly tracker, which handles one entry per cycle
// while its two-entry result queue is not full. Entries are registered in the
// command queue and results in the result queue; results are popped like a
// FIFO. Depends on bmsfs_pkg, bmsfs_front, bmsfs_cmdq and bmsfs_back.
module bms_frame_sync_and_cell_assembly_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_cmd,
    output logic [7:0]  o_pay0,
    output logic [7:0]  o_pay1,
    output logic [7:0]  o_pay2,
    output logic [7:0]  o_pay3,
    output logic [7:0]  o_pay4,
    output logic [7:0]  o_pay5,
    output logic [7:0]  o_pay6,
    output logic [7:0]  o_pay7,
    output logic [2:0]  o_cell_status,
    output logic [3:0]  o_cell_slot,
    output logic        o_cells_complete
);
    import bmsfs_pkg::*;

    logic       accept;
    logic       q_wr;
    logic       q_rd;
    logic       q_empty;
    t_cmd_entry q_in;
    t_cmd_entry q_out;
    t_result    res;

    assign accept = push && !full;

    bmsfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .o_wr      (q_wr),
        .o_entry   (q_in)
    );

    bmsfs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_full  (full),
        .o_data  (q_out)
    );

    bmsfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_data    (q_out),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_frame_cmd      = res.fcmd;
    assign o_pay0           = res.pay[0];
    assign o_pay1           = res.pay[1];
    assign o_pay2           = res.pay[2];
    assign o_pay3           = res.pay[3];
    assign o_pay4           = res.pay[4];
    assign o_pay5           = res.pay[5];
    assign o_pay6           = res.pay[6];
    assign o_pay7           = res.pay[7];
    assign o_cell_status    = res.status;
    assign o_cell_slot      = res.slot;
    assign o_cells_complete = res.complete;

endmodule

// File: rtl/bmsfs_checker.sv
// Port-level checks for the frame sync block, attached by bind.
// Uses bmsfs_pkg for the cell status codes.
module bmsfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_frame_cmd,
    input logic [2:0] o_cell_status,
    input logic [3:0] o_cell_slot,
    input logic       o_cells_complete
);
    import bmsfs_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting word lost without pop");

    a_status_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cell_status != CS_NONE) |-> (o_frame_cmd == CMD_CELLS))
        else $error("cell status on a non-cell frame");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_cell_status == CS_NONE || o_cell_status == CS_RANGE))
            |-> (o_cell_slot == 4'd0))
        else $error("slot set without a valid index");

    a_assembled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cell_status == CS_ASSEMBLED) |-> o_cells_complete)
        else $error("already-assembled status without complete flag");

endmodule

bind bms_frame_sync_and_cell_assembly_top bmsfs_checker u_bmsfs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_frame_cmd      (o_frame_cmd),
    .o_cell_status    (o_cell_status),
    .o_cell_slot      (o_cell_slot),
    .o_cells_complete (o_cells_complete)
);
